// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation and status codes, and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
	localparam int DEN_WIDTH   = DATA_WIDTH - 1;
	localparam int FUNC_WIDTH  = 3;
	localparam int STAT_WIDTH  = 2;

	// Operation codes
	localparam logic [FUNC_WIDTH-1:0] FUNC_NORM = 3'd0;
	localparam logic [FUNC_WIDTH-1:0] FUNC_ADD  = 3'd1;
	localparam logic [FUNC_WIDTH-1:0] FUNC_SUB  = 3'd2;
	localparam logic [FUNC_WIDTH-1:0] FUNC_MUL  = 3'd3;
	localparam logic [FUNC_WIDTH-1:0] FUNC_DIV  = 3'd4;
	localparam logic [FUNC_WIDTH-1:0] FUNC_CMP  = 3'd5;

	// Status codes
	localparam logic [STAT_WIDTH-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_WIDTH-1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [STAT_WIDTH-1:0] ST_OVERFLOW = 2'd2;

	// Reducer operand source
	localparam logic [1:0] RED_LHS = 2'd0;
	localparam logic [1:0] RED_RHS = 2'd1;
	localparam logic [1:0] RED_RES = 2'd2;

	// Multiplier step
	localparam logic [1:0] MUL_0 = 2'd0;
	localparam logic [1:0] MUL_1 = 2'd1;
	localparam logic [1:0] MUL_2 = 2'd2;

	typedef struct packed {
		logic       load;
		logic       red_start;
		logic [1:0] red_sel;
		logic       cap_a;
		logic       cap_b;
		logic       cap_r;
		logic       mul_en;
		logic [1:0] mul_step;
		logic       emit;
	} rau_cmd_t;

	typedef struct packed {
		logic                  red_done;
		logic                  red_err;
		logic [FUNC_WIDTH-1:0] func;
	} rau_stat_t;

endpackage

// File: hdl/rau_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one operation and two operand fractions per word.
// ----------------------------------------------------------------------------
interface rau_req_if import rau_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [FUNC_WIDTH-1:0]        func;
	logic signed [DATA_WIDTH-1:0] lhs_num;
	logic signed [DATA_WIDTH-1:0] lhs_den;
	logic signed [DATA_WIDTH-1:0] rhs_num;
	logic signed [DATA_WIDTH-1:0] rhs_den;

	modport source (output valid, func, lhs_num, lhs_den, rhs_num, rhs_den, input ready);
	modport sink   (input valid, func, lhs_num, lhs_den, rhs_num, rhs_den, output ready);
endinterface

// File: hdl/rau_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one reduced fraction, compare flags and status per word.
// ----------------------------------------------------------------------------
interface rau_rsp_if import rau_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_num;
	logic [DEN_WIDTH-1:0]         result_den;
	logic                         less;
	logic                         equal;
	logic [STAT_WIDTH-1:0]        status;

	modport source (output valid, result_num, result_den, less, equal, status, input ready);
	modport sink   (input valid, result_num, result_den, less, equal, status, output ready);
endinterface

// File: hdl/rau_reduce.sv
// ----------------------------------------------------------------------------
// Fraction reducer
// Moves the sign to the numerator, finds the GCD of the magnitudes one
// binary step per cycle, divides both by it one quotient bit per cycle and
// checks that the result fits.
// ----------------------------------------------------------------------------
module rau_reduce import rau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [PROD_WIDTH-1:0] num,
	input  logic signed [PROD_WIDTH-1:0] den,
	output logic                         done,
	output logic [STAT_WIDTH-1:0]        status,
	output logic signed [DATA_WIDTH-1:0] res_num,
	output logic [DEN_WIDTH-1:0]         res_den
);

	localparam int SH_W = $clog2(PROD_WIDTH);
	localparam logic [PROD_WIDTH-1:0] MAX_POS = {{(PROD_WIDTH-DATA_WIDTH+1){1'b0}},
		{(DATA_WIDTH-1){1'b1}}};

	typedef enum logic [4:0] {
		R_IDLE = 5'b00001,
		R_GCD  = 5'b00010,
		R_DIV  = 5'b00100,
		R_CHK  = 5'b01000,
		R_DONE = 5'b10000
	} red_state_t;

	function automatic logic [PROD_WIDTH-1:0] mag(input logic signed [PROD_WIDTH-1:0] v);
		return v[PROD_WIDTH-1] ? PROD_WIDTH'(-v) : PROD_WIDTH'(v);
	endfunction

	red_state_t                   state_q;
	logic [PROD_WIDTH-1:0]        a_q, b_q, g_q;
	logic [PROD_WIDTH-1:0]        qn_q, qd_q, rn_q, rd_q;
	logic [SH_W-1:0]              k_q, cnt_q;
	logic                         neg_q;
	logic [STAT_WIDTH-1:0]        st_q;
	logic signed [DATA_WIDTH-1:0] num_q;
	logic [DEN_WIDTH-1:0]         den_q;

	logic [PROD_WIDTH:0]          tn, td;
	logic                         ovf;
	logic [DATA_WIDTH-1:0]        n_trunc;

	// one restoring division step on both dividends
	assign tn = {rn_q, qn_q[PROD_WIDTH-1]};
	assign td = {rd_q, qd_q[PROD_WIDTH-1]};

	assign ovf = (qd_q > MAX_POS) || (qn_q > (MAX_POS + PROD_WIDTH'(neg_q)));
	assign n_trunc = qn_q[DATA_WIDTH-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (start) begin
						k_q <= '0;
						if (den == '0 || num == '0) state_q <= R_DONE;
						else state_q <= R_GCD;
					end
				end
				R_GCD: begin
					if (a_q == b_q) begin
						cnt_q   <= '0;
						state_q <= R_DIV;
					end else if (!a_q[0] && !b_q[0]) begin
						k_q <= k_q + 1'b1;
					end
				end
				R_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SH_W'(PROD_WIDTH - 1)) state_q <= R_CHK;
				end
				R_CHK:   state_q <= R_DONE;
				R_DONE:  state_q <= R_IDLE;
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (start) begin
					a_q   <= mag(num);
					b_q   <= mag(den);
					qn_q  <= mag(num);
					qd_q  <= mag(den);
					neg_q <= num[PROD_WIDTH-1] ^ den[PROD_WIDTH-1];
					num_q <= '0;
					den_q <= DEN_WIDTH'(1);
					st_q  <= (den == '0) ? ST_ZERO_DEN : ST_OK;
				end
			end
			R_GCD: begin
				if (a_q == b_q) begin
					g_q  <= a_q << k_q;
					rn_q <= '0;
					rd_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q > b_q) begin
					a_q <= (a_q - b_q) >> 1;
				end else begin
					b_q <= (b_q - a_q) >> 1;
				end
			end
			R_DIV: begin
				if (tn >= {1'b0, g_q}) begin
					rn_q <= PROD_WIDTH'(tn - {1'b0, g_q});
					qn_q <= {qn_q[PROD_WIDTH-2:0], 1'b1};
				end else begin
					rn_q <= tn[PROD_WIDTH-1:0];
					qn_q <= {qn_q[PROD_WIDTH-2:0], 1'b0};
				end
				if (td >= {1'b0, g_q}) begin
					rd_q <= PROD_WIDTH'(td - {1'b0, g_q});
					qd_q <= {qd_q[PROD_WIDTH-2:0], 1'b1};
				end else begin
					rd_q <= td[PROD_WIDTH-1:0];
					qd_q <= {qd_q[PROD_WIDTH-2:0], 1'b0};
				end
			end
			R_CHK: begin
				if (ovf) begin
					st_q  <= ST_OVERFLOW;
					num_q <= '0;
					den_q <= DEN_WIDTH'(1);
				end else begin
					st_q  <= ST_OK;
					num_q <= neg_q ? $signed(-n_trunc) : $signed(n_trunc);
					den_q <= qd_q[DEN_WIDTH-1:0];
				end
			end
			default: ;
		endcase
	end

	assign done    = (state_q == R_DONE);
	assign status  = st_q;
	assign res_num = num_q;
	assign res_den = den_q;

endmodule

// File: hdl/rau_datapath.sv
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Holds the operands, the normalized fractions and the cross products,
// shares one multiplier and one reducer, and drives the response word.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rau_cmd_t                     cmd,
	output rau_stat_t                    stat,
	input  logic [FUNC_WIDTH-1:0]        func,
	input  logic signed [DATA_WIDTH-1:0] lhs_num,
	input  logic signed [DATA_WIDTH-1:0] lhs_den,
	input  logic signed [DATA_WIDTH-1:0] rhs_num,
	input  logic signed [DATA_WIDTH-1:0] rhs_den,
	output logic signed [DATA_WIDTH-1:0] result_num,
	output logic [DEN_WIDTH-1:0]         result_den,
	output logic                         less,
	output logic                         equal,
	output logic [STAT_WIDTH-1:0]        status
);

	logic [FUNC_WIDTH-1:0]        func_q;
	logic signed [DATA_WIDTH-1:0] ln_q, ld_q, rn_q, rd_q;
	logic signed [DATA_WIDTH-1:0] an_q, bn_q, r_num_q;
	logic [DEN_WIDTH-1:0]         ad_q, bd_q, r_den_q;
	logic signed [PROD_WIDTH-1:0] m0_q, m1_q, m2_q;
	logic [STAT_WIDTH-1:0]        st_q;

	logic signed [DATA_WIDTH-1:0] mul_x, mul_y, ad_s, bd_s;
	logic signed [PROD_WIDTH-1:0] prod, res_n, diff;
	logic signed [PROD_WIDTH-1:0] red_n, red_d;
	logic                         red_done;
	logic [STAT_WIDTH-1:0]        red_st;
	logic signed [DATA_WIDTH-1:0] red_num;
	logic [DEN_WIDTH-1:0]         red_den;

	logic signed [DATA_WIDTH-1:0] o_num;
	logic [DEN_WIDTH-1:0]         o_den;
	logic                         o_less, o_equal;

	assign ad_s = $signed({1'b0, ad_q});
	assign bd_s = $signed({1'b0, bd_q});

	// capture operands and track status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_OK;
			func_q <= FUNC_NORM;
		end else if (cmd.load) begin
			st_q   <= ST_OK;
			func_q <= func;
		end else if (cmd.cap_a || cmd.cap_b || cmd.cap_r) begin
			st_q <= red_st;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ln_q <= lhs_num;
			ld_q <= lhs_den;
			rn_q <= rhs_num;
			rd_q <= rhs_den;
		end
		if (cmd.cap_a) begin
			an_q <= red_num;
			ad_q <= red_den;
		end
		if (cmd.cap_b) begin
			bn_q <= red_num;
			bd_q <= red_den;
		end
		if (cmd.cap_r) begin
			r_num_q <= red_num;
			r_den_q <= red_den;
		end
	end

	// select multiplier operands for each step
	always_comb begin
		case (cmd.mul_step)
			MUL_0: begin
				mul_x = an_q;
				mul_y = (func_q == FUNC_MUL) ? bn_q : bd_s;
			end
			MUL_1: begin
				mul_x = bn_q;
				mul_y = ad_s;
			end
			MUL_2: begin
				mul_x = ad_s;
				mul_y = (func_q == FUNC_DIV) ? bn_q : bd_s;
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign prod = mul_x * mul_y;

	// register each cross product
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_step)
				MUL_0:   m0_q <= prod;
				MUL_1:   m1_q <= prod;
				MUL_2:   m2_q <= prod;
				default: ;
			endcase
		end
	end

	// combine cross products into the raw result numerator
	assign diff = m0_q - m1_q;
	always_comb begin
		case (func_q)
			FUNC_ADD: res_n = m0_q + m1_q;
			FUNC_SUB: res_n = diff;
			default:  res_n = m0_q;
		endcase
	end

	// pick the reducer source
	always_comb begin
		case (cmd.red_sel)
			RED_LHS: begin
				red_n = PROD_WIDTH'(ln_q);
				red_d = PROD_WIDTH'(ld_q);
			end
			RED_RHS: begin
				red_n = PROD_WIDTH'(rn_q);
				red_d = PROD_WIDTH'(rd_q);
			end
			RED_RES: begin
				red_n = res_n;
				red_d = m2_q;
			end
			default: begin
				red_n = '0;
				red_d = '0;
			end
		endcase
	end

	rau_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.red_start),
		.num     (red_n),
		.den     (red_d),
		.done    (red_done),
		.status  (red_st),
		.res_num (red_num),
		.res_den (red_den)
	);

	assign stat.red_done = red_done;
	assign stat.red_err  = (red_st != ST_OK);
	assign stat.func     = func_q;

	// form the response word
	always_comb begin
		o_num   = '0;
		o_den   = DEN_WIDTH'(1);
		o_less  = 1'b0;
		o_equal = 1'b0;
		if (st_q == ST_OK) begin
			case (func_q)
				FUNC_NORM: begin
					o_num = an_q;
					o_den = ad_q;
				end
				FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
					o_num = r_num_q;
					o_den = r_den_q;
				end
				FUNC_CMP: begin
					o_less  = diff[PROD_WIDTH-1];
					o_equal = (an_q == bn_q) && (ad_q == bd_q);
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_num <= o_num;
			result_den <= o_den;
			less       <= o_less;
			equal      <= o_equal;
			status     <= st_q;
		end
	end

endmodule

// File: hdl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences operand reduction, cross multiplication, result reduction and
// the hand-off of each response word.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  rau_stat_t stat,
	output rau_cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_RA_GO   = 11'b00000000010,
		S_RA_WAIT = 11'b00000000100,
		S_RB_GO   = 11'b00000001000,
		S_RB_WAIT = 11'b00000010000,
		S_MUL0    = 11'b00000100000,
		S_MUL1    = 11'b00001000000,
		S_MUL2    = 11'b00010000000,
		S_RR_GO   = 11'b00100000000,
		S_RR_WAIT = 11'b01000000000,
		S_EMIT    = 11'b10000000000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        valid_q;
	logic        emit_ok;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = valid_q;
	assign emit_ok   = !valid_q || rsp_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RA_GO;
				end
			end
			S_RA_GO: begin
				cmd.red_sel = RED_LHS;
				if (stat.func > FUNC_CMP) begin
					state_d = S_EMIT;
				end else begin
					cmd.red_start = 1'b1;
					state_d       = S_RA_WAIT;
				end
			end
			S_RA_WAIT: begin
				if (stat.red_done) begin
					cmd.cap_a = 1'b1;
					if (stat.red_err || stat.func == FUNC_NORM) state_d = S_EMIT;
					else state_d = S_RB_GO;
				end
			end
			S_RB_GO: begin
				cmd.red_sel   = RED_RHS;
				cmd.red_start = 1'b1;
				state_d       = S_RB_WAIT;
			end
			S_RB_WAIT: begin
				if (stat.red_done) begin
					cmd.cap_b = 1'b1;
					if (stat.red_err) state_d = S_EMIT;
					else state_d = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_0;
				state_d      = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_1;
				state_d      = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_2;
				state_d      = (stat.func == FUNC_CMP) ? S_EMIT : S_RR_GO;
			end
			S_RR_GO: begin
				cmd.red_sel   = RED_RES;
				cmd.red_start = 1'b1;
				state_d       = S_RR_WAIT;
			end
			S_RR_WAIT: begin
				if (stat.red_done) begin
					cmd.cap_r = 1'b1;
					state_d   = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_ok) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// advance state and hold the response valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) valid_q <= 1'b1;
			else if (rsp_ready) valid_q <= 1'b0;
		end
	end

endmodule

// File: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Normalizes, adds, subtracts, multiplies, divides or compares 32-bit
// fractions and returns GCD-reduced results with status.
// ----------------------------------------------------------------------------
// One word is worked at a time. Each fraction reduction runs on a shared
// reducer: one binary GCD step per cycle, then bit-serial division of both
// magnitudes by the GCD, plus setup and a check that the result fits. A
// normalize takes one reduction; add, subtract, multiply and divide take two
// operand reductions, three cross products on the one multiplier and one
// result reduction; compare takes the two operand reductions and the three
// cross products only. An unused code skips every reduction, and a zero
// numerator or zero denominator skips the GCD loop and the division. The
// response is held in an output register, so a new request can be taken
// while the last response waits.
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rau_req_if.sink    req,
	rau_rsp_if.source  rsp
);

	rau_cmd_t  cmd;
	rau_stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rau_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (req.func),
		.lhs_num    (req.lhs_num),
		.lhs_den    (req.lhs_den),
		.rhs_num    (req.rhs_num),
		.rhs_den    (req.rhs_den),
		.result_num (rsp.result_num),
		.result_den (rsp.result_den),
		.less       (rsp.less),
		.equal      (rsp.equal),
		.status     (rsp.status)
	);

endmodule

// File: hdl/rau_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level checks on the response word and the request pacing.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic signed [DATA_WIDTH-1:0] result_num,
	input logic [DEN_WIDTH-1:0]         result_den,
	input logic                         less,
	input logic                         equal,
	input logic [STAT_WIDTH-1:0]        status
);

	// an error word carries 0/1 and no compare flags
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |->
			result_num == '0 && result_den == DEN_WIDTH'(1) && !less && !equal)
		else $error("error word not cleared");

	// the denominator is never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> result_den != '0)
		else $error("zero denominator in response");

	// less and equal exclude each other
	a_cmp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(less && equal))
		else $error("less and equal both set");

	// one word in flight: no accept right after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_num) && $stable(status))
		else $error("stalled response changed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.result_num (rsp.result_num),
	.result_den (rsp.result_den),
	.less       (rsp.less),
	.equal      (rsp.equal),
	.status     (rsp.status)
);

// File: dv/rau_tb_if.sv
// ----------------------------------------------------------------------------
// Testbench package
// Expected response word type shared by the testbench checker.
// ----------------------------------------------------------------------------
package rau_tb_pkg;
	import rau_pkg::*;

	// One expected response word
	typedef struct {
		logic signed [DATA_WIDTH-1:0] num;
		logic [DEN_WIDTH-1:0]         den;
		logic                         less;
		logic                         equal;
		logic [STAT_WIDTH-1:0]        status;
	} rau_answer_t;
endpackage

// File: dv/rau_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches the request and response channels, predicts every response from
// the accepted request and compares it field by field, in order.
// ----------------------------------------------------------------------------
module rau_tb_checker import rau_pkg::*; import rau_tb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	rau_req_if     req,
	rau_rsp_if     rsp,
	output int     fail_count,
	output int     pending
);

	rau_answer_t answers[$];

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
		while (a != 0 && b != 0) begin
			if (a >= b)
				a = a % b;
			else
				b = b % a;
		end
		return (a == 0) ? b : a;
	endfunction

	// Reduce n/d into sign-on-numerator lowest terms; return status
	function automatic logic [STAT_WIDTH-1:0] lowest_terms(longint n, longint d,
			output longint rn, output longint rd);
		longint unsigned mn, md, g, lim;
		bit neg;
		rn = 0;
		rd = 1;
		if (d == 0)
			return ST_ZERO_DEN;
		if (n == 0)
			return ST_OK;
		neg = (n < 0) != (d < 0);
		mn = mag(n);
		md = mag(d);
		g = euclid(mn, md);
		mn = mn / g;
		md = md / g;
		lim = (64'd1 << (DATA_WIDTH - 1)) - 1;
		if (md > lim || mn > (neg ? lim + 1 : lim))
			return ST_OVERFLOW;
		rn = neg ? -longint'(mn) : longint'(mn);
		rd = longint'(md);
		return ST_OK;
	endfunction

	function automatic rau_answer_t evaluate(logic [FUNC_WIDTH-1:0] op,
			logic signed [DATA_WIDTH-1:0] ln, logic signed [DATA_WIDTH-1:0] ld,
			logic signed [DATA_WIDTH-1:0] rn, logic signed [DATA_WIDTH-1:0] rd);
		rau_answer_t ans;
		logic [STAT_WIDTH-1:0] st;
		longint an, ad, bn, bd, qn, qd;
		ans = '{num: '0, den: 1, less: 0, equal: 0, status: ST_OK};
		if (op > FUNC_CMP)
			return ans;
		qn = 0;
		qd = 1;
		st = lowest_terms(longint'(ln), longint'(ld), an, ad);
		if (st == ST_OK && op != FUNC_NORM)
			st = lowest_terms(longint'(rn), longint'(rd), bn, bd);
		if (st == ST_OK) begin
			case (op)
				FUNC_NORM: begin qn = an; qd = ad; end
				FUNC_ADD:  st = lowest_terms(an * bd + bn * ad, ad * bd, qn, qd);
				FUNC_SUB:  st = lowest_terms(an * bd - bn * ad, ad * bd, qn, qd);
				FUNC_MUL:  st = lowest_terms(an * bn, ad * bd, qn, qd);
				FUNC_DIV:  st = lowest_terms(an * bd, ad * bn, qn, qd);
				default: begin
					ans.less = (an * bd - bn * ad) < 0;
					ans.equal = (an == bn) && (ad == bd);
				end
			endcase
		end
		if (st != ST_OK) begin
			ans.less = 0;
			ans.equal = 0;
		end else begin
			ans.num = qn[DATA_WIDTH-1:0];
			ans.den = qd[DEN_WIDTH-1:0];
		end
		ans.status = st;
		return ans;
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	assign pending = answers.size();

	// Predict on request words, compare on response words
	always @(posedge clk or negedge arst_n) begin
		rau_answer_t want;
		if (!arst_n) begin
			fail_count = 0;
			answers.delete();
		end else begin
			if (req.valid && req.ready)
				answers.push_back(evaluate(req.func, req.lhs_num, req.lhs_den,
					req.rhs_num, req.rhs_den));
			if (rsp.valid && rsp.ready) begin
				if (answers.size() == 0) begin
					report("response word with nothing expected");
				end else begin
					want = answers.pop_front();
					if (rsp.result_num !== want.num)
						report($sformatf("num %0d want %0d", rsp.result_num, want.num));
					if (rsp.result_den !== want.den)
						report($sformatf("den %0d want %0d", rsp.result_den, want.den));
					if (rsp.less !== want.less)
						report($sformatf("less %b want %b", rsp.less, want.less));
					if (rsp.equal !== want.equal)
						report($sformatf("equal %b want %b", rsp.equal, want.equal));
					if (rsp.status !== want.status)
						report($sformatf("status %0d want %0d", rsp.status, want.status));
				end
			end
		end
	end

endmodule

// File: dv/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed corner fractions, then random operations with random gaps
// and response stalls, including one long stall; the checker scores results.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int RANDOM_WORDS = 700;
	localparam int STALL_LIMIT  = 20000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	bit   steady;
	bit   stalling;

	rau_req_if req ();
	rau_rsp_if rsp ();

	rational_arithmetic_unit dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	rau_tb_checker chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return $urandom_range(0, 1) ? 1 : -1;
			4, 5: return $signed($urandom_range(0, 40)) - 20;
			6: return $signed($urandom_range(0, 4000)) - 2000;
			default: return $urandom();
		endcase
	endfunction

	// Offer one word and hold it until accepted
	task automatic send(logic [FUNC_WIDTH-1:0] op, logic signed [DATA_WIDTH-1:0] ln,
			logic signed [DATA_WIDTH-1:0] ld, logic signed [DATA_WIDTH-1:0] rn,
			logic signed [DATA_WIDTH-1:0] rd);
		while (!steady && $urandom_range(0, 99) < 27) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid   <= 1;
		req.func    <= op;
		req.lhs_num <= ln;
		req.lhs_den <= ld;
		req.rhs_num <= rn;
		req.rhs_den <= rd;
		do @(posedge clk); while (!req.ready);
	endtask

	// Receiver: random stalls, a steady stretch and one long hold-off
	initial begin
		rsp.ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stalling) begin
				rsp.ready <= 0;
				repeat (3000) @(posedge clk);
				stalling = 0;
			end
			rsp.ready <= steady || ($urandom_range(0, 99) >= 27);
		end
	end

	// Watchdog on cycles with no accepted word
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || stalling)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic signed [DATA_WIDTH-1:0] mn, mx;
		int waited;
		mn = 32'sh8000_0000;
		mx = 32'sh7fff_ffff;
		steady = 0;
		stalling = 0;
		arst_n <= 0;
		req.valid <= 0;
		req.func <= FUNC_NORM;
		req.lhs_num <= '0;
		req.lhs_den <= '0;
		req.rhs_num <= '0;
		req.rhs_den <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: each operation, zero denominators, overflow, unused codes
		send(FUNC_NORM, 6, -4, 0, 0);
		send(FUNC_NORM, 0, -7, 1, 1);
		send(FUNC_NORM, 5, 0, 1, 1);
		send(FUNC_NORM, mn, -1, 0, 0);
		send(FUNC_NORM, mn, mn, 0, 0);
		send(FUNC_NORM, mx, mn, 0, 0);
		send(FUNC_ADD, 1, 2, 1, 3);
		send(FUNC_ADD, mx, 1, mx, 1);
		send(FUNC_ADD, 1, 0, 1, 0);
		send(FUNC_SUB, 1, 3, 1, 3);
		send(FUNC_SUB, mn, 1, 1, 1);
		send(FUNC_SUB, 2, 3, 1, 0);
		send(FUNC_MUL, -2, 3, 3, -2);
		send(FUNC_MUL, mn, 1, mn, 1);
		send(FUNC_MUL, mx, mn, mn, mx);
		send(FUNC_DIV, 1, 2, 0, 5);
		send(FUNC_DIV, -3, 4, 9, -8);
		send(FUNC_DIV, 1, mx, mx, 1);
		send(FUNC_CMP, 1, 2, 2, 4);
		send(FUNC_CMP, -1, 2, 1, 3);
		send(FUNC_CMP, 1, 3, -1, 2);
		send(FUNC_CMP, 1, 0, 1, 1);
		send(3'd6, 1, 0, 1, 0);
		send(3'd7, mx, mn, -1, 3);

		// Random words; a steady stretch, then a long response hold-off
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 150) steady = 1;
			if (i == 250) steady = 0;
			if (i == 300) stalling = 1;
			send(FUNC_WIDTH'($urandom_range(0, 7)), pick_value(), pick_value(),
				pick_value(), pick_value());
		end
		req.valid <= 0;

		waited = 0;
		while (pending != 0 && waited < STALL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (700) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: rational_arithmetic_unit.f
hdl/rau_pkg.sv
hdl/rau_req_if.sv
hdl/rau_rsp_if.sv
hdl/rau_reduce.sv
hdl/rau_datapath.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
hdl/rau_checker.sv
dv/rau_tb_if.sv
dv/rau_checker.sv
dv/rational_arithmetic_unit_tb.sv
